@@ rtl/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t                        op;
        logic signed [DATA_W-1:0]   value;
    } in_t;

    typedef struct packed {
        status_t                    status;
        logic signed [DATA_W-1:0]   removed_value;
        logic [COUNT_W-1:0]         entry_count;
    } out_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       shift_in;
        logic       shift_out;
        logic       result_load;
        status_t    result_status;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic       op_remove;
        logic       full;
        logic       empty;
    } dp_stat_t;

endpackage

@@ rtl/sorted_priority_queue_top.sv @@
// top level of the sorted priority queue
// result: valid in the response state, which follows the execute state after the accepting edge, and held until taken
// one transaction at a time in three steps (accept, compare-and-shift, result); no new accept until the result is taken
// the compare-and-shift step updates the cells of the sorted row together
// reset: synchronous active-low aresetn empties the queue and returns the controller to idle
// stored entries need no clearing; only entries below the fill count are ever read
module sorted_priority_queue_top (
    input  logic            aclk,
    input  logic            aresetn,
    // input transactions: insert or remove
    input  logic            s_valid,
    output logic            s_ready,
    input  spq_pkg::in_t    s_payload,
    // result transactions: status, removed value, entry count
    output logic            m_valid,
    input  logic            m_ready,
    output spq_pkg::out_t   m_payload
);

    // command and status between controller and datapath
    spq_pkg::cmd_t      cmd;
    spq_pkg::dp_stat_t  stat;

    // controller: idle -> execute -> hold result until taken
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: operand capture, sorted cell row, fill count, result register
    spq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_payload  (s_payload),
        .cmd         (cmd),
        .stat        (stat),
        .out_payload (m_payload)
    );

endmodule

@@ rtl/spq_ctrl.sv @@
// controller state machine for the sorted priority queue
module spq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  spq_pkg::dp_stat_t   stat,
    output spq_pkg::cmd_t       cmd
);

    spq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        s_ready           = 1'b0;
        m_valid           = 1'b0;
        cmd.capture       = 1'b0;
        cmd.shift_in      = 1'b0;
        cmd.shift_out     = 1'b0;
        cmd.result_load   = 1'b0;
        cmd.result_status = spq_pkg::ST_DONE;
        unique case (state_reg)
            spq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                cmd.result_load = 1'b1;
                if (stat.op_remove) begin
                    if (stat.empty) begin
                        cmd.result_status = spq_pkg::ST_UNDERFLOW;
                    end else begin
                        cmd.shift_out = 1'b1;
                    end
                end else begin
                    if (stat.full) begin
                        cmd.result_status = spq_pkg::ST_OVERFLOW;
                    end else begin
                        cmd.shift_in = 1'b1;
                    end
                end
                state_next = spq_pkg::S_RESP;
            end
            spq_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/spq_dp.sv @@
// datapath for the sorted priority queue: row of compare-and-shift cells
module spq_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  spq_pkg::in_t        in_payload,
    input  spq_pkg::cmd_t       cmd,
    output spq_pkg::dp_stat_t   stat,
    output spq_pkg::out_t       out_payload
);

    spq_pkg::op_t                       op_reg;
    logic signed [spq_pkg::DATA_W-1:0]  value_reg;
    logic signed [spq_pkg::DATA_W-1:0]  entries_reg [spq_pkg::CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0]  entries_next [spq_pkg::CAPACITY];
    logic [spq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [spq_pkg::CAPACITY-1:0]       at_or_past;
    spq_pkg::out_t                      out_reg;

    assign stat.op_remove = (op_reg == spq_pkg::OP_REMOVE);
    assign stat.full      = (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign stat.empty     = (count_reg == '0);

    // per cell: the new value belongs here or before (entry greater, or empty cell)
    always_comb begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            at_or_past[i] = (spq_pkg::CNT_W'(i) >= count_reg) ||
                            (value_reg < entries_reg[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            entries_next[i] = entries_reg[i];
        end
        count_next = count_reg;
        if (cmd.shift_in) begin
            entries_next[0] = at_or_past[0] ? value_reg : entries_reg[0];
            for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
                if (at_or_past[i]) begin
                    entries_next[i] = at_or_past[i-1] ? entries_reg[i-1] : value_reg;
                end
            end
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end else if (cmd.shift_out) begin
            for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
                entries_next[i] = entries_reg[i+1];
            end
            count_next = count_reg - spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_payload.op;
            value_reg <= in_payload.value;
        end
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            entries_reg[i] <= entries_next[i];
        end
        if (cmd.result_load) begin
            out_reg.status        <= cmd.result_status;
            out_reg.removed_value <= cmd.shift_out ? entries_reg[0] : '0;
            out_reg.entry_count   <= spq_pkg::COUNT_W'(count_next);
        end
    end

    assign out_payload = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_in |-> !stat.full && !cmd.shift_out)
        else $error("insert while full");

    a_no_remove_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_out |-> !stat.empty)
        else $error("remove while empty");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_in |=> count_reg == $past(count_reg) + spq_pkg::CNT_W'(1))
        else $error("count did not advance on insert");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= spq_pkg::CNT_W'(2) |-> entries_reg[0] <= entries_reg[1])
        else $error("front entries out of order");

endmodule
